FILE: design/ipv4_address_anonymizer_macros.svh
// Assertion macros shared by the anonymizer RTL.
`ifndef IPV4_ADDRESS_ANONYMIZER_MACROS_SVH
`define IPV4_ADDRESS_ANONYMIZER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define IPANON_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IPANON_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ipanon_pkg.sv
// Package with types, constants and SipHash helper functions of the anonymizer.
`default_nettype none
package ipanon_pkg;

  localparam int PREFIX_BITS = 12;
  localparam int ROUND_COUNT = 4;
  localparam int LA = (PREFIX_BITS - 1) / 2 + 1;
  localparam int LB = PREFIX_BITS / 2;

  // One sip round per stage: eight per Feistel hash, six per lower-bit hash.
  localparam int FEISTEL_STEPS = 8;
  localparam int BIT_STEPS = 6;
  localparam int FEISTEL_STAGES = ROUND_COUNT * FEISTEL_STEPS;
  localparam int NSTAGE = FEISTEL_STAGES + (32 - PREFIX_BITS) * BIT_STEPS;

  localparam logic [31:0] PREFIX_MASK = ~(32'hffff_ffff >> PREFIX_BITS);
  localparam logic [31:0] LOW_MASK = ~PREFIX_MASK;

  localparam logic [63:0] V0_CONST = 64'h736f6d6570736575;
  localparam logic [63:0] V1_CONST = 64'h646f72616e646f6d;
  localparam logic [63:0] V2_CONST = 64'h6c7967656e657261;
  localparam logic [63:0] V3_CONST = 64'h7465646279746573;
  localparam logic [63:0] LEN8_WORD = 64'h0800_0000_0000_0000;
  localparam logic [7:0] LEN4_TAG = 8'h04;
  localparam logic [63:0] FINAL_XOR = 64'h0000_0000_0000_00ff;
  localparam int HASH_BIT = 56;

  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  localparam logic [31:0] KEY0_RST = 32'd622796055;
  localparam logic [31:0] KEY1_RST = 32'd892283689;
  localparam logic [31:0] KEY2_RST = 32'd1195588923;
  localparam logic [31:0] KEY3_RST = 32'd1498632009;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] res;
    sip_t        v;
  } stage_t;

  function automatic sip_t sip_round(sip_t s);
    sip_t t;
    t = s;
    t.v0 = t.v0 + t.v1; t.v1 = {t.v1[50:0], t.v1[63:51]}; t.v1 = t.v1 ^ t.v0;
    t.v0 = {t.v0[31:0], t.v0[63:32]};
    t.v2 = t.v2 + t.v3; t.v3 = {t.v3[47:0], t.v3[63:48]}; t.v3 = t.v3 ^ t.v2;
    t.v0 = t.v0 + t.v3; t.v3 = {t.v3[42:0], t.v3[63:43]}; t.v3 = t.v3 ^ t.v0;
    t.v2 = t.v2 + t.v1; t.v1 = {t.v1[46:0], t.v1[63:47]}; t.v1 = t.v1 ^ t.v2;
    t.v2 = {t.v2[31:0], t.v2[63:32]};
    return t;
  endfunction

  function automatic sip_t sip_init(logic [63:0] k0, logic [63:0] k1);
    sip_t t;
    t.v0 = k0 ^ V0_CONST;
    t.v1 = k1 ^ V1_CONST;
    t.v2 = k0 ^ V2_CONST;
    t.v3 = k1 ^ V3_CONST;
    return t;
  endfunction

  function automatic logic [63:0] sip_hash(sip_t s);
    return s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
  endfunction

  // Message word of a Feistel hash: the other half, left-aligned in bytes 0 and 1.
  function automatic logic [63:0] feistel_word(logic [31:0] res, logic even);
    logic [15:0] h16;
    h16 = '0;
    if (even) h16[15 -: LB] = res[31-LA -: LB];
    else h16[15 -: LA] = res[31 -: LA];
    return {48'h0, h16[7:0], h16[15:8]};
  endfunction

  function automatic logic [31:0] feistel_apply(logic [31:0] res, logic [63:0] h, logic even);
    logic [15:0] mask16;
    logic [31:0] r;
    mask16 = {h[7:0], h[15:8]};
    r = res;
    if (even) r[31 -: LA] = r[31 -: LA] ^ mask16[15 -: LA];
    else r[31-LA -: LB] = r[31-LA -: LB] ^ mask16[15 -: LB];
    return r;
  endfunction

  // Message word of a lower-bit hash: the four result bytes, network order, plus length.
  function automatic logic [63:0] bit_word(logic [31:0] res, logic [4:0] pos);
    logic [31:0] r;
    r = res;
    r[pos] = 1'b1;
    return {LEN4_TAG, 24'h0, r[7:0], r[15:8], r[23:16], r[31:24]};
  endfunction

  function automatic logic [31:0] bit_apply(logic [31:0] res, logic [31:0] addr,
                                            logic [63:0] h, logic [4:0] pos);
    logic [31:0] r;
    r = res;
    r[pos] = addr[pos] ^ h[HASH_BIT];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/ipv4_address_anonymizer.sv
// Top level of the prefix-preserving IPv4 address anonymizer.
//
// Usage: present an address on in_address_in with start high; it is taken at
// that clock edge (busy stays low, so one word may enter every cycle).
// The anonymized address appears on out_address_out with out_valid high for
// exactly one cycle, after passing every pipeline stage and the output register,
// in the order the words entered.
// Throughput is one word per cycle: every sip round of every hash owns one
// pipeline stage, 8 stages per Feistel round and 6 per lower address bit.
// The receiver cannot stall, so results never wait.
// The SipHash key is written through cfg_we / cfg_index / cfg_data, one 32-bit
// word per write, by the user only while no word is in flight; unenforced.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the
// default key; no word is lost or repeated outside of reset.
`default_nettype none
module ipv4_address_anonymizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_address_in,
  output logic             out_valid,
  output logic [31:0]      out_address_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  `include "ipv4_address_anonymizer_macros.svh"

  localparam int N = ipanon_pkg::NSTAGE;

  logic [31:0] key0_r, key1_r, key2_r, key3_r;
  logic [63:0] k0, k1;

  ipanon_pkg::stage_t src     [N];
  ipanon_pkg::stage_t stage_nxt[N];
  ipanon_pkg::stage_t stage_r [N];
  logic [N-1:0]       vld_r;
  logic               out_valid_r;
  logic [31:0]        out_addr_r;
  logic [31:0]        out_addr_nxt;
  logic               in_acc;

  assign busy = 1'b0;
  assign in_acc = start && !busy;
  assign k0 = {key1_r, key0_r};
  assign k1 = {key3_r, key2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= ipanon_pkg::KEY0_RST;
      key1_r <= ipanon_pkg::KEY1_RST;
      key2_r <= ipanon_pkg::KEY2_RST;
      key3_r <= ipanon_pkg::KEY3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ipanon_pkg::REG_KEY0: key0_r <= cfg_data;
        ipanon_pkg::REG_KEY1: key1_r <= cfg_data;
        ipanon_pkg::REG_KEY2: key2_r <= cfg_data;
        ipanon_pkg::REG_KEY3: key3_r <= cfg_data;
        default: ;
      endcase
    end
  end

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_stage
      localparam bit IS_FEI = (j < ipanon_pkg::FEISTEL_STAGES);
      localparam int TB = j - ipanon_pkg::FEISTEL_STAGES;
      localparam int K = IS_FEI ? (j % ipanon_pkg::FEISTEL_STEPS)
                                : (TB % ipanon_pkg::BIT_STEPS);
      localparam bit EVEN = (((j / ipanon_pkg::FEISTEL_STEPS) % 2) == 0);
      localparam int POS = IS_FEI ? 0
                           : 31 - (ipanon_pkg::PREFIX_BITS + TB / ipanon_pkg::BIT_STEPS);
      localparam bit PREV_FEI = (j > 0) && ((j - 1) < ipanon_pkg::FEISTEL_STAGES);
      localparam bit PREV_EVEN = (j > 0) &&
                                 ((((j - 1) / ipanon_pkg::FEISTEL_STEPS) % 2) == 0);
      localparam int PREV_POS = PREV_FEI || (j == 0) ? 0 :
        31 - (ipanon_pkg::PREFIX_BITS + (j - 1 - ipanon_pkg::FEISTEL_STAGES) /
              ipanon_pkg::BIT_STEPS);

      if (j == 0) begin : g_entry
        always_comb begin
          src[j].addr = in_address_in;
          src[j].res  = in_address_in & ipanon_pkg::PREFIX_MASK;
          src[j].v    = '0;
        end
      end else begin : g_link
        assign src[j] = stage_r[j-1];
      end

      always_comb begin
        ipanon_pkg::stage_t s;
        logic [63:0] h;
        logic [63:0] m;
        s = src[j];
        h = ipanon_pkg::sip_hash(src[j].v);
        // The first step of each hash folds in the result of the hash before it.
        if (K == 0 && j > 0) begin
          if (PREV_FEI) s.res = ipanon_pkg::feistel_apply(s.res, h, PREV_EVEN);
          else s.res = ipanon_pkg::bit_apply(s.res, s.addr, h, 5'(PREV_POS));
        end
        if (IS_FEI) m = ipanon_pkg::feistel_word(s.res, EVEN);
        else m = ipanon_pkg::bit_word(s.res, 5'(POS));
        if (K == 0) begin
          s.v = ipanon_pkg::sip_init(k0, k1);
          s.v.v3 = s.v.v3 ^ m;
        end else if (K == 2) begin
          s.v.v0 = s.v.v0 ^ m;
          if (IS_FEI) s.v.v3 = s.v.v3 ^ ipanon_pkg::LEN8_WORD;
          else s.v.v2 = s.v.v2 ^ ipanon_pkg::FINAL_XOR;
        end else if (K == 4 && IS_FEI) begin
          s.v.v0 = s.v.v0 ^ ipanon_pkg::LEN8_WORD;
          s.v.v2 = s.v.v2 ^ ipanon_pkg::FINAL_XOR;
        end
        s.v = ipanon_pkg::sip_round(s.v);
        stage_nxt[j] = s;
      end
    end
  endgenerate

  // The last stage always hashes the final address bit, at position zero.
  assign out_addr_nxt = ipanon_pkg::bit_apply(stage_r[N-1].res, stage_r[N-1].addr,
                                              ipanon_pkg::sip_hash(stage_r[N-1].v), 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[N-2:0], in_acc};
      out_valid_r <= vld_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      stage_r[i] <= stage_nxt[i];
    end
    out_addr_r <= out_addr_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_address_out = out_addr_r;

  `IPANON_ASSERT_NEXT(a_enter, in_acc, vld_r[0], "accepted word did not enter the pipeline")
  `IPANON_ASSERT_NEXT(a_exit, vld_r[N-1], out_valid, "last stage word did not reach the output")
  `IPANON_ASSERT_NOW(a_low_clear, vld_r[0],
    (stage_r[0].res & ipanon_pkg::LOW_MASK) == 32'h0, "lower result bits not clear at entry")
  `IPANON_ASSERT_NOW(a_last_bit, vld_r[N-1], stage_r[N-1].res[0] == 1'b0,
    "final address bit resolved early")

endmodule
`default_nettype wire

FILE: tb/ipv4_address_anonymizer_test.sv
// Self-checking testbench for the prefix-preserving IPv4 address anonymizer.
`timescale 1ns / 100ps
`default_nettype none
module ipv4_address_anonymizer_test;

  localparam int RUN_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 170;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_address_in = '0;
  logic out_valid;
  logic [31:0] out_address_out;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = ipanon_pkg::REG_KEY0;
  logic [31:0] cfg_data = '0;

  logic [31:0] pending_words[$];
  logic [31:0] expected_addrs[$];
  logic [31:0] key_copy[4];
  int failures = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;

  ipv4_address_anonymizer uut (.*);

  always #5 clk = ~clk;

  function automatic void sip_mix(inout logic [63:0] a, b, c, d);
    a = a + b; b = (b << 13) | (b >> 51); b = b ^ a; a = (a << 32) | (a >> 32);
    c = c + d; d = (d << 16) | (d >> 48); d = d ^ c;
    a = a + d; d = (d << 21) | (d >> 43); d = d ^ a;
    c = c + b; b = (b << 17) | (b >> 47); b = b ^ c; c = (c << 32) | (c >> 32);
  endfunction

  // Keyed hash over one or two message blocks; the last block carries the length.
  function automatic logic [63:0] keyed_hash(logic [63:0] m0, logic [63:0] m1, bit two);
    logic [63:0] k0, k1, a, b, c, d;
    k0 = {key_copy[1], key_copy[0]};
    k1 = {key_copy[3], key_copy[2]};
    a = k0 ^ 64'h736f6d6570736575;
    b = k1 ^ 64'h646f72616e646f6d;
    c = k0 ^ 64'h6c7967656e657261;
    d = k1 ^ 64'h7465646279746573;
    d = d ^ m0; sip_mix(a, b, c, d); sip_mix(a, b, c, d); a = a ^ m0;
    if (two) begin
      d = d ^ m1; sip_mix(a, b, c, d); sip_mix(a, b, c, d); a = a ^ m1;
    end
    c = c ^ 64'hff;
    repeat (4) sip_mix(a, b, c, d);
    return a ^ b ^ c ^ d;
  endfunction

  function automatic logic [15:0] round_mask(logic [15:0] other);
    logic [63:0] h;
    h = keyed_hash({48'h0, other[7:0], other[15:8]}, 64'h0800_0000_0000_0000, 1'b1);
    return {h[7:0], h[15:8]};
  endfunction

  function automatic logic [31:0] anonymize(logic [31:0] addr);
    localparam int PB = ipanon_pkg::PREFIX_BITS;
    localparam int HL = (PB - 1) / 2 + 1;
    localparam int HR = PB / 2;
    logic [15:0] left, right, mask_l, mask_r;
    logic [31:0] res, probe;
    logic [63:0] h;
    mask_l = 16'hffff << (16 - HL);
    mask_r = 16'hffff << (16 - HR);
    left = 16'(addr >> (32 - HL)) << (16 - HL);
    right = 16'((addr >> (32 - PB)) & ((32'd1 << HR) - 1)) << (16 - HR);
    for (int r = 0; r < ipanon_pkg::ROUND_COUNT; r++) begin
      if (r % 2 == 0) left = (left ^ round_mask(right)) & mask_l;
      else right = (right ^ round_mask(left)) & mask_r;
    end
    res = (32'(left >> (16 - HL)) << (32 - HL)) |
          (32'(right >> (16 - HR)) << (32 - PB));
    for (int p = 31 - PB; p >= 0; p--) begin
      probe = res | (32'd1 << p);
      h = keyed_hash({8'h04, 24'h0, probe[7:0], probe[15:8], probe[23:16], probe[31:24]},
                     64'h0, 1'b0);
      res[p] = addr[p] ^ h[56];
    end
    return res;
  endfunction

  // Driver: bursts of words separated by random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_addrs.push_back(anonymize(pending_words[0]));
        void'(pending_words.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() > (start && !busy ? 0 : 0) &&
                   !(start && !busy && pending_words.size() == 0)) begin
        start <= 1'b1;
        in_address_in <= pending_words[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_addrs.size() == 0) begin
        $error("address_out: unexpected word %h", out_address_out);
        failures++;
      end else begin
        if (out_address_out !== expected_addrs[0]) begin
          $error("address_out: expected %h, actual %h", expected_addrs[0], out_address_out);
          failures++;
        end
        void'(expected_addrs.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("ipv4_address_anonymizer test failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() != 0 || start || expected_addrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(logic [31:0] w0, w1, w2, w3);
    logic [31:0] words[4];
    words = '{w0, w1, w2, w3};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= words[i];
      key_copy[i] = words[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int count);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: pending_words.push_back($urandom);
        // Words sharing a prefix with the previous ones exercise prefix preservation.
        1: pending_words.push_back((base & ipanon_pkg::PREFIX_MASK) |
                                   ($urandom & ipanon_pkg::LOW_MASK));
        2: pending_words.push_back(base ^ (32'd1 << $urandom_range(0, 31)));
        default: begin
          base = $urandom;
          pending_words.push_back(base);
        end
      endcase
    end
  endtask

  initial begin
    key_copy = '{ipanon_pkg::KEY0_RST, ipanon_pkg::KEY1_RST,
                 ipanon_pkg::KEY2_RST, ipanon_pkg::KEY3_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: extremes, single bits, the prefix boundary.
    pending_words = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                      32'hfff0_0000, 32'h000f_ffff, 32'h0010_0000, 32'hffef_ffff,
                      32'haaaa_aaaa, 32'h5555_5555, 32'hfc00_0000, 32'h03f0_0000,
                      32'hc0a8_0001, 32'hc0a8_0002, 32'hc0a8_ff01, 32'h0a00_0001,
                      32'h0800_0000, 32'h0400_0000, 32'h7fff_ffff, 32'hfffe_ffff};
    queue_random(180);
    drain();

    load_key('0, '0, '0, '0);
    pending_words = '{32'h0000_0000, 32'hffff_ffff, 32'h1234_5678};
    queue_random(160);
    drain();

    load_key('1, '1, '1, '1);
    pending_words = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0001};
    queue_random(160);
    drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    queue_random(160);
    drain();

    load_key(ipanon_pkg::KEY0_RST, '1, $urandom, '0);
    queue_random(160);
    drain();

    if (failures == 0 && expected_addrs.size() == 0) begin
      $display("ipv4_address_anonymizer test passed");
    end else begin
      $display("ipv4_address_anonymizer test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
